// ===== hdl/boxcar_moving_average_assert.svh =====
// assertion macros for the boxcar moving average block
// used by the top level only; no other dependencies
`ifndef BOXCAR_MOVING_AVERAGE_ASSERT_SVH
`define BOXCAR_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define BMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, disabled while reset is high
`define BMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/bma_pkg.sv =====
// shared constants, codes and interface types of the boxcar moving average
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package bma_pkg;

   localparam int RING_DEPTH  = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int PTR_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(RING_DEPTH + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
   localparam int STEP_BITS = $clog2(SUM_BITS);

   // register field widths
   localparam int LEN_BITS       = 7;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [LEN_BITS-1:0]    WINDOW_LENGTH_RESET  = 7'd64;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_FLOOR_RESET   = 16'd0;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_CEILING_RESET = 16'd4095;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
   localparam logic [1:0] REG_SAMPLE_FLOOR   = 2'd1;
   localparam logic [1:0] REG_SAMPLE_CEILING = 2'd2;

   // request opcode
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic evaluate;
      logic div_step;
      logic load_result;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_divide;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/bma_dpath.sv =====
// datapath: sample ring, running sum, window position and restoring divider
// depends on bma_pkg; sequenced by bma_ctrl
`default_nettype none

module bma_dpath import bma_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output stat_type                    stat,
   input  wire logic                   req_op,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic [LEN_BITS-1:0]    window_length,
   input  wire logic [SAMPLE_BITS-1:0] sample_floor,
   input  wire logic [SAMPLE_BITS-1:0] sample_ceiling,
   output logic [SAMPLE_BITS-1:0]      rsp_average,
   output logic                        rsp_status
);

   typedef enum logic [1:0] {
      KIND_AVERAGE = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];

   logic                   op_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] old_ff;
   kind_type               kind_ff;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [PTR_BITS-1:0]    pos_ff, pos_in;
   logic                   full_ff, full_in;
   logic [SUM_BITS-1:0]    quot_ff;
   logic [CNT_BITS-1:0]    rem_ff;
   logic [CNT_BITS-1:0]    div_ff;
   logic [SAMPLE_BITS-1:0] average_ff;
   logic                   status_ff;

   logic                   in_range;
   logic                   sample_ok;
   logic [CNT_BITS-1:0]    eff_len;
   logic [CNT_BITS-1:0]    pos_inc;
   logic                   wrap;
   logic [SUM_BITS-1:0]    sum_less;
   logic [SUM_BITS-1:0]    sum_new;
   logic [CNT_BITS-1:0]    divisor_new;
   logic [CNT_BITS:0]      shifted;
   logic [CNT_BITS:0]      diff;
   logic                   take;
   logic [CNT_BITS-1:0]    rem_step;
   logic [SAMPLE_BITS-1:0] average_sat;

   assign in_range  = (sample_ff >= sample_floor) && (sample_ff <= sample_ceiling);
   assign sample_ok = (op_ff == OP_SAMPLE) && in_range;
   assign stat.needs_divide = sample_ok;

   // window length zero acts as one, anything past the ring depth is clamped
   always_comb begin
      if (window_length == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (int'(window_length) > RING_DEPTH) begin
         eff_len = CNT_BITS'(RING_DEPTH);
      end else begin
         eff_len = CNT_BITS'(window_length);
      end
   end

   assign pos_inc     = CNT_BITS'(pos_ff) + CNT_BITS'(1);
   assign wrap        = pos_inc >= eff_len;
   assign sum_less    = full_ff ? (sum_ff - SUM_BITS'(old_ff)) : sum_ff;
   assign sum_new     = sum_less + SUM_BITS'(sample_ff);
   assign divisor_new = (full_ff || wrap) ? eff_len : pos_inc;

   always_comb begin
      sum_in  = sum_ff;
      pos_in  = pos_ff;
      full_in = full_ff;
      if (cmd.evaluate) begin
         if (op_ff == OP_CLEAR) begin
            sum_in  = '0;
            pos_in  = '0;
            full_in = 1'b0;
         end else if (in_range) begin
            sum_in  = sum_new;
            pos_in  = wrap ? '0 : PTR_BITS'(pos_inc);
            full_in = full_ff | wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         pos_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         pos_ff  <= pos_in;
         full_ff <= full_in;
      end
   end

   // ring memory: one write port, one registered read at the write position
   always_ff @(posedge clock) begin
      if (cmd.evaluate && sample_ok) begin
         ring[pos_ff] <= sample_ff;
      end
      old_ff <= ring[pos_ff];
   end

   // one restoring step per cycle, quotient bits shift in from the right
   assign shifted  = {rem_ff, quot_ff[SUM_BITS-1]};
   assign diff     = shifted - {1'b0, div_ff};
   assign take     = shifted >= {1'b0, div_ff};
   assign rem_step = take ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];

   assign average_sat = (|quot_ff[SUM_BITS-1:SAMPLE_BITS]) ? '1 : quot_ff[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= req_op;
         sample_ff <= req_sample;
      end
      if (cmd.evaluate) begin
         if (op_ff == OP_CLEAR) begin
            kind_ff <= KIND_CLEAR;
         end else if (in_range) begin
            kind_ff <= KIND_AVERAGE;
         end else begin
            kind_ff <= KIND_REJECT;
         end
         quot_ff <= sum_new;
         rem_ff  <= '0;
         div_ff  <= divisor_new;
      end
      if (cmd.div_step) begin
         quot_ff <= {quot_ff[SUM_BITS-2:0], take};
         rem_ff  <= rem_step;
      end
      if (cmd.load_result) begin
         case (kind_ff)
            KIND_AVERAGE: begin
               average_ff <= average_sat;
               status_ff  <= 1'b0;
            end
            KIND_REJECT: begin
               average_ff <= '0;
               status_ff  <= 1'b1;
            end
            default: begin
               average_ff <= '0;
               status_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_average = average_ff;
   assign rsp_status  = status_ff;

endmodule

`default_nettype wire

// ===== hdl/bma_ctrl.sv =====
// controller: accepts a request, sequences update, divide and result load
// depends on bma_pkg; drives bma_dpath through cmd_type
`default_nettype none

module bma_ctrl import bma_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EVAL   = 4'b0010,
      S_DIV    = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.evaluate = 1'b1;
            step_in      = STEP_BITS'(SUM_BITS - 1);
            state_in     = stat.needs_divide ? S_DIV : S_FINISH;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         S_FINISH: begin
            // wait here only while the previous result is still unclaimed
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/boxcar_moving_average.sv =====
// Boxcar moving average over the last N samples, N from window_length.
// Request channel (req_valid/req_ready): req_op selects a new sample or a
// window clear; req_sample is the raw sample. Result channel
// (rsp_valid/rsp_ready): rsp_average is the integer mean of the window,
// rsp_status flags a sample outside [sample_floor, sample_ceiling], which
// is dropped with average 0. A clear answers average 0, status 0.
// A sample passes from accept to rsp_valid through an update state, the 22
// steps of the radix-2 divider and a load state; clear or reject skips the
// divider. One request is in flight at a time; the next can be taken in
// the cycle after the result is loaded, so the bit-serial divider sets the
// rate at which samples pass. The output register holds one result, so
// a request can be accepted while the receiver stalls; the following result
// then waits until the first is taken.
// Reset clears the window (sum, position, full flag) and loads register
// defaults; ring contents are not cleared and need no clearing pass.
// Registers at paddr 0x0 window_length, 0x4 sample_floor, 0x8 sample_ceiling;
// write them only while the block is idle.
`default_nettype none

module boxcar_moving_average import bma_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_op,
   input  wire logic [SAMPLE_BITS-1:0]   req_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [SAMPLE_BITS-1:0]        rsp_average,
   output logic                          rsp_status,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

`include "boxcar_moving_average_assert.svh"

   logic [LEN_BITS-1:0]    window_length_ff;
   logic [SAMPLE_BITS-1:0] sample_floor_ff;
   logic [SAMPLE_BITS-1:0] sample_ceiling_ff;
   logic                   csr_write;
   logic [1:0]             csr_index;
   cmd_type                dp_cmd;
   stat_type               dp_stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_LENGTH_RESET;
         sample_floor_ff   <= SAMPLE_FLOOR_RESET;
         sample_ceiling_ff <= SAMPLE_CEILING_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WINDOW_LENGTH: begin
               window_length_ff <= pwdata[LEN_BITS-1:0];
            end
            REG_SAMPLE_FLOOR: begin
               sample_floor_ff <= pwdata[SAMPLE_BITS-1:0];
            end
            REG_SAMPLE_CEILING: begin
               sample_ceiling_ff <= pwdata[SAMPLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WINDOW_LENGTH:  prdata = CSR_DATA_BITS'(window_length_ff);
         REG_SAMPLE_FLOOR:   prdata = CSR_DATA_BITS'(sample_floor_ff);
         REG_SAMPLE_CEILING: prdata = CSR_DATA_BITS'(sample_ceiling_ff);
         default:            prdata = '0;
      endcase
   end

   bma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   bma_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .req_op         (req_op),
      .req_sample     (req_sample),
      .window_length  (window_length_ff),
      .sample_floor   (sample_floor_ff),
      .sample_ceiling (sample_ceiling_ff),
      .rsp_average    (rsp_average),
      .rsp_status     (rsp_status)
   );

   // the block is busy in the cycle after taking a request
   `BMA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // a rejected sample never reports a nonzero average
   `BMA_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && rsp_status, rsp_average == '0)
   // a result load always presents a valid result next cycle
   `BMA_ASSERT_NEXT(a_load_shows_result, clock, reset, dp_cmd.load_result, rsp_valid)

endmodule

`default_nettype wire

// ===== test/tb_boxcar_moving_average.sv =====
// self-checking testbench for boxcar_moving_average: random and directed requests,
// results predicted in-line and compared as they leave the block
// depends on bma_pkg and the boxcar_moving_average rtl only
`timescale 1ns / 1ps

module tb_boxcar_moving_average;
   import bma_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic                   op;
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] average;
      logic                   status;
   } request_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] average;
      logic                   status;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid  = 1'b0;
   logic                     req_ready;
   logic                     req_op     = OP_SAMPLE;
   logic [SAMPLE_BITS-1:0]   req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_ready  = 1'b0;
   logic [SAMPLE_BITS-1:0]   rsp_average;
   logic                     rsp_status;
   logic                     psel       = 1'b0;
   logic                     penable    = 1'b0;
   logic                     pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr      = '0;
   logic [CSR_DATA_BITS-1:0] pwdata     = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // shadow of the block: configuration and window state
   logic [LEN_BITS-1:0]    cfg_length  = WINDOW_LENGTH_RESET;
   logic [SAMPLE_BITS-1:0] cfg_floor   = SAMPLE_FLOOR_RESET;
   logic [SAMPLE_BITS-1:0] cfg_ceiling = SAMPLE_CEILING_RESET;
   logic [SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
   bit                     ring_written [RING_DEPTH];
   logic [SUM_BITS-1:0]    window_sum   = '0;
   logic [PTR_BITS-1:0]    write_pos    = '0;
   bit                     window_full  = 1'b0;

   request_type pending_requests [$];
   result_type  expected_results [$];
   request_type in_flight;
   result_type  oldest;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;
   bit hold_req    = 1'b0;
   bit hold_done   = 1'b0;
   bit hold_active = 1'b0;
   int hold_left   = 0;

   boxcar_moving_average DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_status  (rsp_status),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #4 clock = ~clock;

   task automatic note_failure(input string what, input logic [31:0] expected,
                               input logic [31:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s: expected %0d, got %0d", what, expected, actual);
      end
   endtask

   function automatic bit in_range(input logic [SAMPLE_BITS-1:0] s);
      return s >= cfg_floor && s <= cfg_ceiling;
   endfunction

   // advances the shadow window by one request and returns its result
   function automatic void predict_average(input logic op, input logic [SAMPLE_BITS-1:0] s,
                                           output logic [SAMPLE_BITS-1:0] avg,
                                           output logic status);
      int unsigned n;
      int unsigned next_pos;
      int unsigned divisor;
      logic [SUM_BITS-1:0] quotient;
      avg = '0;
      status = 1'b0;
      if (op == OP_CLEAR) begin
         window_sum = '0;
         write_pos = '0;
         window_full = 1'b0;
      end else if (!in_range(s)) begin
         status = 1'b1;
      end else begin
         n = (cfg_length == 0) ? 1 : (cfg_length > RING_DEPTH) ? RING_DEPTH : cfg_length;
         if (window_full) window_sum = window_sum - ring_copy[write_pos];
         ring_copy[write_pos] = s;
         ring_written[write_pos] = 1'b1;
         window_sum = window_sum + s;
         next_pos = write_pos + 1;
         if (next_pos >= n) begin
            next_pos = 0;
            window_full = 1'b1;
         end
         write_pos = next_pos[PTR_BITS-1:0];
         divisor = window_full ? n : next_pos;
         if (divisor == 0) divisor = 1;
         quotient = SUM_BITS'(window_sum / divisor);
         avg = (quotient > 65535) ? '1 : quotient[SAMPLE_BITS-1:0];
      end
   endfunction

   // a sample that would pull a never-written ring entry out of the sum gets a clear first
   function automatic void queue_request(input logic op, input logic [SAMPLE_BITS-1:0] s);
      request_type item;
      if (op == OP_SAMPLE && in_range(s) && window_full && !ring_written[write_pos]) begin
         item.op = OP_CLEAR;
         item.sample = s;
         predict_average(item.op, item.sample, item.average, item.status);
         pending_requests.push_back(item);
      end
      item.op = op;
      item.sample = s;
      predict_average(item.op, item.sample, item.average, item.status);
      pending_requests.push_back(item);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int roll;
      roll = $urandom_range(99);
      if (cfg_floor > cfg_ceiling || roll < 10) return SAMPLE_BITS'($urandom_range(65535));
      if (roll < 18) return $urandom_range(1) ? cfg_floor : cfg_ceiling;
      if (roll < 26) begin
         if (cfg_floor > 0 && $urandom_range(1)) return cfg_floor - 16'd1;
         if (cfg_ceiling < 16'hFFFF) return cfg_ceiling + 16'd1;
         return SAMPLE_BITS'($urandom_range(65535));
      end
      return SAMPLE_BITS'($urandom_range(cfg_ceiling, cfg_floor));
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [CSR_DATA_BITS-1:0] stored;
      stored = (index == REG_WINDOW_LENGTH) ? (value & 32'h7F) : (value & 32'hFFFF);
      case (index)
         REG_WINDOW_LENGTH:  cfg_length  = stored[LEN_BITS-1:0];
         REG_SAMPLE_FLOOR:   cfg_floor   = stored[SAMPLE_BITS-1:0];
         REG_SAMPLE_CEILING: cfg_ceiling = stored[SAMPLE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // read back
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== stored) note_failure("register readback", stored, prdata);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         if ($urandom_range(99) < 4) queue_request(OP_CLEAR, SAMPLE_BITS'($urandom_range(65535)));
         else queue_request(OP_SAMPLE, pick_sample());
      end
      wait_idle();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back('{average: in_flight.average, status: in_flight.status});
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_op <= in_flight.op;
               req_sample <= in_flight.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               note_failure("result with no request pending", 0, rsp_average);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_average !== oldest.average)
                  note_failure("average", oldest.average, rsp_average);
               if (rsp_status !== oldest.status)
                  note_failure("status", oldest.status, rsp_status);
            end
         end
         rsp_ready <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // one long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_left <= 0;
      end else if (hold_active) begin
         hold_left <= hold_left - 1;
         if (hold_left <= 1) hold_active <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_active <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: range edges, rejects above the ceiling, clear ignores its sample
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'd0);
      queue_request(OP_SAMPLE, 16'd4095);
      queue_request(OP_SAMPLE, 16'd4096);
      queue_request(OP_SAMPLE, 16'hFFFF);
      queue_request(OP_SAMPLE, 16'd1234);
      queue_request(OP_CLEAR, 16'hFFFF);
      queue_request(OP_SAMPLE, 16'd7);
      wait_idle();

      // full window of two, then shrink it: sum exceeds the field and saturates
      write_register(REG_WINDOW_LENGTH, 2);
      write_register(REG_SAMPLE_CEILING, 32'hFFFF);
      @(negedge clock);
      queue_request(OP_CLEAR, 16'd0);
      queue_request(OP_SAMPLE, 16'hFFFF);
      queue_request(OP_SAMPLE, 16'hFFFF);
      wait_idle();
      write_register(REG_WINDOW_LENGTH, 1);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'hFFFF);
      wait_idle();
      // zero length acts as one
      write_register(REG_WINDOW_LENGTH, 0);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'd100);
      wait_idle();
      // length past the ring depth is clamped
      write_register(REG_WINDOW_LENGTH, 127);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'd40000);
      queue_request(OP_SAMPLE, 16'd20000);
      wait_idle();
      // floor above ceiling rejects everything
      write_register(REG_SAMPLE_FLOOR, 100);
      write_register(REG_SAMPLE_CEILING, 50);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'd75);
      queue_request(OP_SAMPLE, 16'd0);
      queue_request(OP_SAMPLE, 16'hFFFF);
      wait_idle();
      write_register(REG_SAMPLE_FLOOR, 32'hFFFF);
      write_register(REG_SAMPLE_CEILING, 32'hFFFF);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'hFFFF);
      queue_request(OP_SAMPLE, 16'hFFFE);
      wait_idle();
      write_register(REG_SAMPLE_FLOOR, 0);
      write_register(REG_SAMPLE_CEILING, 0);
      @(negedge clock);
      queue_request(OP_SAMPLE, 16'd0);
      queue_request(OP_SAMPLE, 16'd1);
      queue_request(OP_CLEAR, 16'h5A5A);
      wait_idle();

      // random phases; the window is not cleared between them
      write_register(REG_WINDOW_LENGTH, 8);
      write_register(REG_SAMPLE_CEILING, 4095);
      run_random(80, 0, 0);

      write_register(REG_WINDOW_LENGTH, 64);
      write_register(REG_SAMPLE_CEILING, 32'hFFFF);
      run_random(100, 60, 0);

      write_register(REG_WINDOW_LENGTH, 1);
      write_register(REG_SAMPLE_FLOOR, 1000);
      write_register(REG_SAMPLE_CEILING, 3000);
      run_random(80, 0, 60);

      write_register(REG_WINDOW_LENGTH, $urandom_range(63, 2));
      write_register(REG_SAMPLE_FLOOR, $urandom_range(2000));
      write_register(REG_SAMPLE_CEILING, $urandom_range(65535, 30000));
      run_random(100, 29, 29);

      write_register(REG_WINDOW_LENGTH, 16);
      write_register(REG_SAMPLE_FLOOR, 0);
      write_register(REG_SAMPLE_CEILING, 32'hFFFF);
      @(negedge clock);
      hold_req = 1'b1;
      run_random(40, 0, 0);

      write_register(REG_WINDOW_LENGTH, 127);
      run_random(100, 29, 29);

      write_register(REG_WINDOW_LENGTH, 0);
      write_register(REG_SAMPLE_FLOOR, 200);
      write_register(REG_SAMPLE_CEILING, 100);
      run_random(20, 60, 60);

      write_register(REG_WINDOW_LENGTH, $urandom_range(64, 1));
      write_register(REG_SAMPLE_FLOOR, $urandom_range(1000));
      write_register(REG_SAMPLE_CEILING, $urandom_range(65535, 1000));
      run_random(130, $urandom_range(60), $urandom_range(60));

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
